// File: hdl/mlfqa_pkg.sv
package mlfqa_pkg;

  localparam int MAX_PROCS = 16;
  localparam int PROC_W    = $clog2(MAX_PROCS);
  localparam int CNT_W     = PROC_W + 1;
  localparam int BURST_W   = 16;
  localparam int WAIT_W    = 8;
  localparam int NUM_LVL   = 3;
  localparam int LVL_W     = 2;
  localparam int OVL_W     = 4;
  localparam int QUANT_W   = 8;

  typedef logic [PROC_W-1:0]                 pid_t;
  typedef logic [CNT_W-1:0]                  cnt_t;
  typedef logic [MAX_PROCS-1:0][PROC_W-1:0]  lvl_arr_t;

  localparam logic [1:0] KIND_RUN  = 2'd0;
  localparam logic [1:0] KIND_OVL  = 2'd1;
  localparam logic [1:0] KIND_IDLE = 2'd2;

  localparam logic [LVL_W-1:0] LV_ONE   = 2'd0;
  localparam logic [LVL_W-1:0] LV_TWO   = 2'd1;
  localparam logic [LVL_W-1:0] LV_THREE = 2'd2;

  localparam logic [1:0] REG_QUANTUM  = 2'd0;
  localparam logic [1:0] REG_OVERHEAD = 2'd1;
  localparam logic [1:0] REG_AGING    = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_AGE2,
    S_AGE3,
    S_PICK,
    S_SRCH,
    S_START,
    S_OVL,
    S_RUN
  } state_t;

  typedef struct packed {
    logic             push_en;
    logic [LVL_W-1:0] push_lv;
    pid_t             push_val;
    logic             rm_en;
    logic [LVL_W-1:0] rm_lv;
    pid_t             rm_pos;
  } list_op_t;

  typedef struct packed {
    logic [1:0] kind;
    pid_t       pid;
    logic       done;
    logic       last;
  } slot_t;

endpackage

// File: hdl/mlfqa_lists.sv
module mlfqa_lists (
  input  logic                clk,
  input  logic                rst,
  input  mlfqa_pkg::list_op_t op,
  output mlfqa_pkg::lvl_arr_t lists  [mlfqa_pkg::NUM_LVL],
  output mlfqa_pkg::cnt_t     counts [mlfqa_pkg::NUM_LVL]
);
  import mlfqa_pkg::*;

  lvl_arr_t arr      [NUM_LVL];
  cnt_t     cnt      [NUM_LVL];
  lvl_arr_t arr_next [NUM_LVL];
  cnt_t     cnt_next [NUM_LVL];

  // remove first (shift down), then append at the new tail
  always_comb begin
    for (int lv = 0; lv < NUM_LVL; lv++) begin
      arr_next[lv] = arr[lv];
      cnt_next[lv] = cnt[lv];
      if (op.rm_en && op.rm_lv == LVL_W'(lv) && CNT_W'(op.rm_pos) < cnt[lv]) begin
        for (int j = 0; j < MAX_PROCS - 1; j++) begin
          if (PROC_W'(j) >= op.rm_pos) begin
            arr_next[lv][j] = arr[lv][j+1];
          end
        end
        cnt_next[lv] = cnt[lv] - CNT_W'(1);
      end
      if (op.push_en && op.push_lv == LVL_W'(lv) && cnt_next[lv] < CNT_W'(MAX_PROCS)) begin
        arr_next[lv][cnt_next[lv][PROC_W-1:0]] = op.push_val;
        cnt_next[lv] = cnt_next[lv] + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int lv = 0; lv < NUM_LVL; lv++) begin
      arr[lv] <= arr_next[lv];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int lv = 0; lv < NUM_LVL; lv++) begin
        cnt[lv] <= '0;
      end
    end else begin
      for (int lv = 0; lv < NUM_LVL; lv++) begin
        cnt[lv] <= cnt_next[lv];
      end
    end
  end

  assign lists  = arr;
  assign counts = cnt;

endmodule

// File: hdl/mlfqa_out_stage.sv
module mlfqa_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  mlfqa_pkg::slot_t in_slot,
  output logic             in_ready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,  // ran_process[3:0], completed[4], zero
  output logic [1:0]       m_tuser,  // slot_kind
  output logic             m_tlast
);
  import mlfqa_pkg::*;

  slot_t held;
  logic  held_valid;

  assign in_ready = !held_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held <= in_slot;
    end
  end

  assign m_tvalid = held_valid;
  assign m_tdata  = {3'b000, held.done, held.pid};
  assign m_tuser  = held.kind;
  assign m_tlast  = held.last;

endmodule

// File: hdl/mlfq_scheduler_with_aging_core.sv
// Admit: accepted in idle, ready again on the next cycle.
// Tick: on transfer the sequencer ages levels two and three, then picks; a new session
// is started (after a shortest-job search over level three when levels one and two are
// empty) and may emit overload slots before the run or idle slot that ends the tick.
// Results go through a one-entry output register; a stalled output holds the sequencer.
// Synchronous active-high reset empties all levels, clears waits and session, restores config.
module mlfq_scheduler_with_aging_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // process_slot[3:0], burst_length[19:4], zero
  input  logic        s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // ran_process[3:0], completed[4], zero
  output logic [1:0]  m_tuser,   // slot_kind
  output logic        m_tlast,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wr_data
);
  import mlfqa_pkg::*;

  state_t state, state_next;

  logic [QUANT_W-1:0] quantum;
  logic [OVL_W-1:0]   overhead;
  logic [WAIT_W-1:0]  aging_limit;

  logic [BURST_W-1:0] rem  [MAX_PROCS];
  logic [WAIT_W-1:0]  wait_cnt [MAX_PROCS];
  logic [MAX_PROCS-1:0] present;

  logic               sess_valid;
  pid_t               sess_pid;
  logic [LVL_W-1:0]   sess_lv;
  logic [BURST_W-1:0] slice_left;
  logic [BURST_W-1:0] limit;
  logic               prev_valid;
  pid_t               prev_pid;
  cnt_t               idx;
  pid_t               best_pos;
  logic [BURST_W-1:0] best_val;
  logic [OVL_W-1:0]   ovl_left;

  list_op_t lop;
  lvl_arr_t lists  [NUM_LVL];
  cnt_t     counts [NUM_LVL];

  logic  emit_valid, out_ready, fire;
  slot_t emit_slot;

  pid_t               in_pid;
  logic [BURST_W-1:0] in_burst;
  logic               admit_ok, tick_go;
  logic [LVL_W-1:0]   cur_lv;
  pid_t               age_pid;
  logic [WAIT_W-1:0]  age_w;
  logic               age_done, age_promote;
  pid_t               srch_pid;
  logic               srch_done;
  logic [BURST_W-1:0] run_rem, slice_dec, qeff;

  mlfqa_lists u_lists (
    .clk    (clk),
    .rst    (rst),
    .op     (lop),
    .lists  (lists),
    .counts (counts)
  );

  mlfqa_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (emit_valid),
    .in_slot  (emit_slot),
    .in_ready (out_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  assign in_pid   = s_tdata[PROC_W-1:0];
  assign in_burst = s_tdata[PROC_W+BURST_W-1:PROC_W];
  assign admit_ok = state == S_IDLE && s_tvalid && !s_tuser
                    && in_burst != '0 && !present[in_pid];
  assign tick_go  = state == S_IDLE && s_tvalid && s_tuser;

  assign cur_lv      = (state == S_AGE3) ? LV_THREE : LV_TWO;
  assign age_pid     = lists[cur_lv][idx[PROC_W-1:0]];
  assign age_w       = (wait_cnt[age_pid] == '1) ? wait_cnt[age_pid]
                                                 : wait_cnt[age_pid] + WAIT_W'(1);
  assign age_done    = idx >= counts[cur_lv];
  assign age_promote = age_w >= aging_limit;

  assign srch_pid  = lists[LV_THREE][idx[PROC_W-1:0]];
  assign srch_done = idx >= counts[LV_THREE];

  assign run_rem   = rem[sess_pid] - BURST_W'(1);
  assign slice_dec = slice_left - BURST_W'(1);
  assign qeff      = (quantum == '0) ? BURST_W'(1) : BURST_W'(quantum);

  assign fire = emit_valid && out_ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (tick_go) state_next = S_AGE2;
      S_AGE2:  if (age_done) state_next = S_AGE3;
      S_AGE3:  if (age_done) state_next = S_PICK;
      S_PICK: begin
        if (sess_valid) begin
          state_next = S_RUN;
        end else if (counts[LV_ONE] != '0 || counts[LV_TWO] != '0) begin
          state_next = S_START;
        end else if (counts[LV_THREE] != '0) begin
          state_next = S_SRCH;
        end else begin
          state_next = S_RUN;
        end
      end
      S_SRCH:  if (srch_done) state_next = S_START;
      S_START: state_next = S_OVL;
      S_OVL:   if (ovl_left == '0) state_next = S_RUN;
      S_RUN:   if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready   = 1'b0;
    lop        = '0;
    emit_valid = 1'b0;
    emit_slot  = '0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (admit_ok) begin
          lop.push_en  = 1'b1;
          lop.push_lv  = LV_ONE;
          lop.push_val = in_pid;
        end
      end
      S_AGE2, S_AGE3: begin
        if (!age_done && age_promote) begin
          lop.rm_en    = 1'b1;
          lop.rm_lv    = cur_lv;
          lop.rm_pos   = idx[PROC_W-1:0];
          lop.push_en  = 1'b1;
          lop.push_lv  = LV_ONE;
          lop.push_val = age_pid;
        end
      end
      S_PICK: begin
        if (!sess_valid) begin
          if (counts[LV_ONE] != '0) begin
            lop.rm_en = 1'b1;
            lop.rm_lv = LV_ONE;
          end else if (counts[LV_TWO] != '0) begin
            lop.rm_en = 1'b1;
            lop.rm_lv = LV_TWO;
          end
        end
      end
      S_SRCH: begin
        if (srch_done) begin
          lop.rm_en  = 1'b1;
          lop.rm_lv  = LV_THREE;
          lop.rm_pos = best_pos;
        end
      end
      S_OVL: begin
        emit_valid     = ovl_left != '0;
        emit_slot.kind = KIND_OVL;
      end
      S_RUN: begin
        emit_valid     = 1'b1;
        emit_slot.last = 1'b1;
        if (!sess_valid) begin
          emit_slot.kind = KIND_IDLE;
        end else begin
          emit_slot.kind = KIND_RUN;
          emit_slot.pid  = sess_pid;
          emit_slot.done = run_rem == '0;
          if (out_ready && run_rem != '0 && slice_dec == '0) begin
            lop.push_en  = 1'b1;
            lop.push_lv  = (sess_lv == LV_ONE) ? LV_TWO : LV_THREE;
            lop.push_val = sess_pid;
          end
        end
      end
      default: ;
    endcase
  end

  // remaining time per process, written on admit and on each run slot
  always_ff @(posedge clk) begin
    if (admit_ok) begin
      rem[in_pid] <= in_burst;
    end else if (state == S_RUN && out_ready && sess_valid) begin
      rem[sess_pid] <= run_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      quantum     <= QUANT_W'(4);
      overhead    <= '0;
      aging_limit <= WAIT_W'(20);
      for (int i = 0; i < MAX_PROCS; i++) begin
        wait_cnt[i] <= '0;
      end
      present    <= '0;
      sess_valid <= 1'b0;
      sess_pid   <= '0;
      sess_lv    <= LV_ONE;
      slice_left <= '0;
      limit      <= '0;
      prev_valid <= 1'b0;
      prev_pid   <= '0;
      idx        <= '0;
      best_pos   <= '0;
      best_val   <= '0;
      ovl_left   <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_QUANTUM:  quantum     <= cfg_wr_data;
          REG_OVERHEAD: overhead    <= cfg_wr_data[OVL_W-1:0];
          REG_AGING:    aging_limit <= cfg_wr_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (admit_ok) begin
            wait_cnt[in_pid] <= '0;
            present[in_pid]  <= 1'b1;
          end
          if (tick_go) idx <= '0;
        end
        S_AGE2, S_AGE3: begin
          if (age_done) begin
            idx <= '0;
          end else if (age_promote) begin
            wait_cnt[age_pid] <= '0;
          end else begin
            wait_cnt[age_pid] <= age_w;
            idx <= idx + CNT_W'(1);
          end
        end
        S_PICK: begin
          if (!sess_valid) begin
            if (counts[LV_ONE] != '0) begin
              sess_pid   <= lists[LV_ONE][0];
              sess_lv    <= LV_ONE;
              limit      <= qeff;
              sess_valid <= 1'b1;
            end else if (counts[LV_TWO] != '0) begin
              sess_pid   <= lists[LV_TWO][0];
              sess_lv    <= LV_TWO;
              limit      <= qeff << 1;
              sess_valid <= 1'b1;
            end else if (counts[LV_THREE] != '0) begin
              best_pos <= '0;
              best_val <= rem[lists[LV_THREE][0]];
              idx      <= CNT_W'(1);
            end
          end
        end
        S_SRCH: begin
          if (srch_done) begin
            sess_pid   <= lists[LV_THREE][best_pos];
            sess_lv    <= LV_THREE;
            sess_valid <= 1'b1;
          end else begin
            if (rem[srch_pid] < best_val) begin
              best_pos <= idx[PROC_W-1:0];
              best_val <= rem[srch_pid];
            end
            idx <= idx + CNT_W'(1);
          end
        end
        S_START: begin
          slice_left <= (sess_lv == LV_THREE || rem[sess_pid] < limit) ? rem[sess_pid]
                                                                       : limit;
          wait_cnt[sess_pid] <= '0;
          ovl_left <= (prev_valid && prev_pid != sess_pid) ? overhead : '0;
        end
        S_OVL: begin
          if (fire) ovl_left <= ovl_left - OVL_W'(1);
        end
        S_RUN: begin
          if (out_ready) begin
            if (!sess_valid) begin
              prev_valid <= 1'b0;
            end else begin
              slice_left <= slice_dec;
              if (run_rem == '0) begin
                sess_valid        <= 1'b0;
                prev_valid        <= 1'b0;
                present[sess_pid] <= 1'b0;
              end else begin
                prev_valid <= 1'b1;
                prev_pid   <= sess_pid;
                if (slice_dec == '0) begin
                  wait_cnt[sess_pid] <= '0;
                  sess_valid         <= 1'b0;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
